>>> hdl/sawl_pkg.sv
// Shared types and constants of the stop-and-wait link endpoint.
`default_nettype none

package sawl_pkg;

    localparam int MAC_W  = 48;
    localparam int TYPE_W = 16;
    localparam int CODE_W = 8;
    localparam int LEN_W  = 11;
    localparam int PID_W  = 32;   // width of the id fields on the ports
    localparam int TICK_W = 8;

    localparam int IN_TDATA_W  = 176;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_TUSER_W = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [LEN_W-1:0] MAX_LEN = 11'd1500;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_MAC      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_TYPE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_TICKS   = 3'd4;

    typedef enum logic [1:0] {
        CMD_SEND = 2'd0,
        CMD_RX   = 2'd1,
        CMD_TICK = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUSY     = 2'd1,
        ST_FILTERED = 2'd2,
        ST_DUP      = 2'd3
    } t_status;

    typedef struct packed {
        logic [MAC_W-1:0]  local_mac;
        logic [MAC_W-1:0]  peer_mac;
        logic [TYPE_W-1:0] protocol_type;
        logic [CODE_W-1:0] ack_code;
        logic [TICK_W-1:0] retry_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        command;
        logic [MAC_W-1:0]  rx_dest_mac;
        logic [MAC_W-1:0]  rx_src_mac;
        logic [TYPE_W-1:0] rx_type;
        logic [CODE_W-1:0] rx_code;
        logic [PID_W-1:0]  rx_id;
        logic [CODE_W-1:0] req_code;
        logic [LEN_W-1:0]  req_length;
    } t_item;

    typedef struct packed {
        logic              tx_valid;
        logic [PID_W-1:0]  tx_id;
        logic [CODE_W-1:0] tx_code;
        logic [LEN_W-1:0]  tx_length;
        logic              deliver_valid;
        logic [PID_W-1:0]  deliver_id;
        logic [CODE_W-1:0] deliver_code;
        logic              awaiting_ack;
        t_status           status;
    } t_result;

    // protocol state that does not scale with the id width
    typedef struct packed {
        logic              waiting;
        logic              pending_valid;
        logic [CODE_W-1:0] held_code;
        logic [LEN_W-1:0]  held_length;
        logic [TICK_W-1:0] retry_timer;
        logic [CODE_W-1:0] pending_code;
    } t_ctl;

endpackage

`default_nettype wire

>>> hdl/sawl_step.sv
// Decision logic of the endpoint: next protocol state and result for one word.
`default_nettype none

module sawl_step #(
    parameter int ID_WIDTH = 32
) (
    input  var sawl_pkg::t_item   i_item,
    input  var sawl_pkg::t_cfg    i_cfg,
    input  var sawl_pkg::t_ctl    i_ctl,
    input  wire [ID_WIDTH-1:0]    i_send_counter,
    input  wire [ID_WIDTH-1:0]    i_last_id,
    input  wire [ID_WIDTH-1:0]    i_pending_id,
    output sawl_pkg::t_ctl        o_ctl,
    output logic [ID_WIDTH-1:0]   o_send_counter,
    output logic [ID_WIDTH-1:0]   o_last_id,
    output logic [ID_WIDTH-1:0]   o_pending_id,
    output sawl_pkg::t_result     o_result
);
    import sawl_pkg::*;

    logic [ID_WIDTH-1:0] w_rid;
    logic [ID_WIDTH-1:0] w_cnt_inc;
    logic                w_match;
    logic [LEN_W-1:0]    w_len;

    assign w_rid     = ID_WIDTH'(i_item.rx_id);
    assign w_cnt_inc = ID_WIDTH'(i_send_counter + 1'b1);
    assign w_match   = (i_item.rx_dest_mac == i_cfg.local_mac) &&
                       (i_item.rx_src_mac == i_cfg.peer_mac) &&
                       (i_item.rx_type == i_cfg.protocol_type);
    assign w_len     = (i_item.req_length > MAX_LEN) ? MAX_LEN : i_item.req_length;

    always_comb begin
        o_ctl          = i_ctl;
        o_send_counter = i_send_counter;
        o_last_id      = i_last_id;
        o_pending_id   = i_pending_id;
        o_result       = '0;
        o_result.status = ST_OK;

        case (t_cmd'(i_item.command))
            CMD_SEND: begin
                if (i_ctl.waiting) begin
                    o_result.status = ST_BUSY;
                end else begin
                    o_ctl.held_code     = i_item.req_code;
                    o_ctl.held_length   = w_len;
                    o_ctl.waiting       = 1'b1;
                    o_ctl.retry_timer   = '0;
                    o_ctl.pending_valid = 1'b0;
                    o_send_counter      = w_cnt_inc;
                    o_result.tx_valid   = 1'b1;
                    o_result.tx_id      = PID_W'(w_cnt_inc);
                    o_result.tx_code    = i_item.req_code;
                    o_result.tx_length  = w_len;
                end
            end
            CMD_RX: begin
                if (!w_match) begin
                    o_result.status = ST_FILTERED;
                end else if (!i_ctl.waiting) begin
                    if (w_rid > i_last_id) begin
                        o_last_id              = w_rid;
                        o_send_counter         = w_cnt_inc;
                        o_result.tx_valid      = 1'b1;
                        o_result.tx_id         = PID_W'(w_cnt_inc);
                        o_result.tx_code       = i_cfg.ack_code;
                        o_result.deliver_valid = 1'b1;
                        o_result.deliver_id    = PID_W'(w_rid);
                        o_result.deliver_code  = i_item.rx_code;
                    end else begin
                        o_result.status = ST_DUP;
                    end
                end else if (i_item.rx_code == i_cfg.ack_code) begin
                    // ack closes the exchange; answer a held frame now
                    o_ctl.waiting       = 1'b0;
                    o_ctl.retry_timer   = '0;
                    o_ctl.pending_valid = 1'b0;
                    if (i_ctl.pending_valid) begin
                        o_send_counter    = w_cnt_inc;
                        o_result.tx_valid = 1'b1;
                        o_result.tx_id    = PID_W'(w_cnt_inc);
                        o_result.tx_code  = i_cfg.ack_code;
                        if (i_pending_id > i_last_id) begin
                            o_last_id              = i_pending_id;
                            o_result.deliver_valid = 1'b1;
                            o_result.deliver_id    = PID_W'(i_pending_id);
                            o_result.deliver_code  = i_ctl.pending_code;
                        end else begin
                            o_result.status = ST_DUP;
                        end
                    end
                end else begin
                    o_ctl.pending_valid = 1'b1;
                    o_ctl.pending_code  = i_item.rx_code;
                    o_pending_id        = w_rid;
                end
            end
            CMD_TICK: begin
                if (i_ctl.waiting) begin
                    if (i_ctl.retry_timer >= i_cfg.retry_ticks) begin
                        o_send_counter     = w_cnt_inc;
                        o_ctl.retry_timer  = '0;
                        o_result.tx_valid  = 1'b1;
                        o_result.tx_id     = PID_W'(w_cnt_inc);
                        o_result.tx_code   = i_ctl.held_code;
                        o_result.tx_length = i_ctl.held_length;
                    end else begin
                        o_ctl.retry_timer = TICK_W'(i_ctl.retry_timer + 1'b1);
                    end
                end
            end
            default: begin
            end
        endcase

        o_result.awaiting_ack = o_ctl.waiting;
    end

endmodule

`default_nettype wire

>>> hdl/stop_and_wait_link_endpoint_core.sv
// Top level of the stop-and-wait link endpoint: stream ports, config, state, result register.
// A word in the input register passes through the decision logic and is loaded into the
// result register once that register is free or being read; one result word per input word.
// Throughput: one word per cycle while the result stream accepts words.
// Reset (synchronous, active low): protocol state cleared, config back to defaults
// (retry_ticks 1, all others 0), both pipeline registers empty.
`default_nettype none

module stop_and_wait_link_endpoint_core #(
    parameter int ID_WIDTH = 32
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // config write channel
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [sawl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [sawl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input stream
    input  wire                                  i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // rx_dest_mac 48, rx_src_mac 48, rx_type 16, rx_code 8, rx_id 32,
    // req_code 8, req_length 11, 5 zero bits
    input  wire  [sawl_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // command 2
    input  wire  [sawl_pkg::IN_TUSER_W-1:0]      i_s_axis_tuser,
    // result stream
    output logic                                 o_m_axis_tvalid,
    input  wire                                  i_m_axis_tready,
    // tx_id 32, tx_code 8, tx_length 11, deliver_id 32, deliver_code 8,
    // awaiting_ack 1, 4 zero bits
    output logic [sawl_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // tx_valid 1, deliver_valid 1, status 2
    output logic [sawl_pkg::OUT_TUSER_W-1:0]     o_m_axis_tuser
);
    import sawl_pkg::*;

    t_cfg                r_cfg;
    t_ctl                r_ctl;
    logic [ID_WIDTH-1:0] r_send_counter;
    logic [ID_WIDTH-1:0] r_last_id;
    logic [ID_WIDTH-1:0] r_pending_id;

    logic                r_in_valid;
    t_item               r_in;
    logic                r_out_valid;
    t_result             r_out;

    t_ctl                n_ctl;
    logic [ID_WIDTH-1:0] n_send_counter;
    logic [ID_WIDTH-1:0] n_last_id;
    logic [ID_WIDTH-1:0] n_pending_id;
    t_result             n_out;

    logic                w_adv;
    logic                w_in_acc;
    t_item               w_item;

    assign o_cfg_ready     = 1'b1;
    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        w_item.command     = i_s_axis_tuser[1:0];
        w_item.rx_dest_mac = i_s_axis_tdata[47:0];
        w_item.rx_src_mac  = i_s_axis_tdata[95:48];
        w_item.rx_type     = i_s_axis_tdata[111:96];
        w_item.rx_code     = i_s_axis_tdata[119:112];
        w_item.rx_id       = i_s_axis_tdata[151:120];
        w_item.req_code    = i_s_axis_tdata[159:152];
        w_item.req_length  = i_s_axis_tdata[170:160];
    end

    sawl_step #(
        .ID_WIDTH (ID_WIDTH)
    ) u_step (
        .i_item         (r_in),
        .i_cfg          (r_cfg),
        .i_ctl          (r_ctl),
        .i_send_counter (r_send_counter),
        .i_last_id      (r_last_id),
        .i_pending_id   (r_pending_id),
        .o_ctl          (n_ctl),
        .o_send_counter (n_send_counter),
        .o_last_id      (n_last_id),
        .o_pending_id   (n_pending_id),
        .o_result       (n_out)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_mac     <= '0;
            r_cfg.peer_mac      <= '0;
            r_cfg.protocol_type <= '0;
            r_cfg.ack_code      <= '0;
            r_cfg.retry_ticks   <= TICK_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LOCAL_MAC:     r_cfg.local_mac     <= i_cfg_data[MAC_W-1:0];
                CFG_PEER_MAC:      r_cfg.peer_mac      <= i_cfg_data[MAC_W-1:0];
                CFG_PROTOCOL_TYPE: r_cfg.protocol_type <= i_cfg_data[TYPE_W-1:0];
                CFG_ACK_CODE:      r_cfg.ack_code      <= i_cfg_data[CODE_W-1:0];
                CFG_RETRY_TICKS:   r_cfg.retry_ticks   <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // protocol state and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl          <= '0;
            r_send_counter <= '0;
            r_last_id      <= '0;
            r_pending_id   <= '0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_adv) begin
                r_ctl          <= n_ctl;
                r_send_counter <= n_send_counter;
                r_last_id      <= n_last_id;
                r_pending_id   <= n_pending_id;
            end
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= w_item;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0, r_out.awaiting_ack, r_out.deliver_code, r_out.deliver_id,
                              r_out.tx_length, r_out.tx_code, r_out.tx_id};
    assign o_m_axis_tuser  = {r_out.status, r_out.deliver_valid, r_out.tx_valid};

    // result reports the waiting flag left by its own word
    a_await_matches_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_adv) |=> (r_out.awaiting_ack == r_ctl.waiting))
        else $error("awaiting_ack differs from waiting state");

    a_pending_needs_wait : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.pending_valid |-> r_ctl.waiting)
        else $error("pending frame held while idle");

    a_deliver_with_ack : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.deliver_valid) |-> (r_out.tx_valid && r_out.tx_length == '0))
        else $error("delivery without acknowledgement");

    a_idle_tx_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.tx_valid) |->
            (r_out.tx_id == '0 && r_out.tx_code == '0 && r_out.tx_length == '0))
        else $error("tx fields set without tx_valid");

    a_len_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.tx_length <= MAX_LEN))
        else $error("tx_length above limit");

endmodule

`default_nettype wire
